FILE: hw/rtl/ccsf_pkg.sv
`default_nettype none

package ccsf_pkg;

  // Field width and fixed-point format: 1.0 = 2^FRAC_BITS.
  localparam int FW        = 17;
  localparam int FRAC_BITS = 16;
  // Quotient bits; a part never exceeds mid, so the quotient is at most 1.0.
  localparam int QB        = FRAC_BITS + 1;
  localparam int NUM_W     = FW + FRAC_BITS;
  localparam int LANES     = 4;

  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  // Lane order inside the part and quotient vectors.
  localparam int L_OPEN  = 0;
  localparam int L_LEFT  = 1;
  localparam int L_RIGHT = 2;
  localparam int L_BOTH  = 3;

  typedef struct packed {
    logic [FW-1:0] rem;
    logic [QB-1:0] lo;
    logic [QB-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [LANES-1:0][FW-1:0] part;
    logic [FW-1:0]            den;
    div_lane_t [LANES-1:0]    lane;
  } div_stage_t;

  typedef struct packed {
    logic [LANES-1:0][FW-1:0] part;
    logic [LANES-1:0][FW-1:0] rel;
  } result_t;

  // Split part * 2^FRAC_BITS into the leading remainder and the bits still to bring down.
  function automatic div_lane_t lane_init(input logic [FW-1:0] part);
    logic [NUM_W-1:0] num;
    div_lane_t        l;
    num   = {part, {FRAC_BITS{1'b0}}};
    l.rem = FW'(num >> QB);
    l.lo  = num[QB-1:0];
    l.quo = '0;
    return l;
  endfunction

  // One restoring-division step: bring down a bit, trial subtract.
  function automatic div_lane_t lane_step(input div_lane_t l, input logic [FW-1:0] den);
    logic [FW:0] t;
    div_lane_t   r;
    t    = {l.rem, l.lo[QB-1]};
    r    = l;
    r.lo = {l.lo[QB-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      r.rem = FW'(t - {1'b0, den});
      r.quo = {l.quo[QB-2:0], 1'b1};
    end else begin
      r.rem = t[FW-1:0];
      r.quo = {l.quo[QB-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cut_cell_shielding_fractions.sv
`default_nettype none
// Cut-cell shielding fractions.
// Input channel (in_valid / in_stall) carries one word per cell: the cell's
// volume fraction and those of its left and right neighbors, unsigned fixed
// point with 1.0 = 65536. The result channel (out_valid / out_stall) returns
// one word per input word, in order: the unshielded, left-only, right-only and
// doubly shielded parts of the cell fraction, and each part divided by the
// cell fraction (truncated; all zero for an empty cell).
// Throughput: one word per clock, every clock, while the receiver keeps up.
// Pipeline: two stages form the drops and parts, then 17 stages run the four
// quotients in parallel, one quotient bit per stage (restoring division),
// then the output register.
// A skid register behind the pipeline catches the word in flight when the
// receiver stalls; in_stall is that skid register's valid bit, so it carries
// no combinational path from out_stall. The pipeline freezes while the skid
// register is full and resumes as soon as the output drains it.
// Reset (rst_n low, synchronous) drops every word in flight and clears
// out_valid; the block takes input in the first cycle after reset.
module cut_cell_shielding_fractions
  import ccsf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire logic [FW-1:0] in_frac_left,
  input  wire logic [FW-1:0] in_frac_mid,
  input  wire logic [FW-1:0] in_frac_right,
  output      logic          out_valid,
  input  wire logic          out_stall,
  output      logic [FW-1:0] out_open_part,
  output      logic [FW-1:0] out_left_part,
  output      logic [FW-1:0] out_right_part,
  output      logic [FW-1:0] out_both_part,
  output      logic [FW-1:0] out_open_rel,
  output      logic [FW-1:0] out_left_rel,
  output      logic [FW-1:0] out_right_rel,
  output      logic [FW-1:0] out_both_rel
);

  // Drop stage.
  logic          a_v_r;
  logic [FW-1:0] dl_r;
  logic [FW-1:0] dr_r;
  logic [FW-1:0] mid_r;

  // Division pipeline: entry stage plus one stage per quotient bit.
  logic       [QB:0] v_r;
  div_stage_t        st_r [QB+1];

  // Output and skid registers.
  logic    out_v_r;
  result_t out_d_r;
  logic    skid_v_r;
  result_t skid_d_r;

  logic       en;
  logic [FW-1:0] dl_nxt, dr_nxt;
  logic [FW-1:0] hi, lo_drop;
  div_stage_t st0_nxt;
  result_t    fin;

  // Advance the whole pipeline unless the skid register holds a word.
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  assign dl_nxt = (in_frac_mid > in_frac_left)  ? in_frac_mid - in_frac_left  : '0;
  assign dr_nxt = (in_frac_mid > in_frac_right) ? in_frac_mid - in_frac_right : '0;

  assign hi      = (dl_r > dr_r) ? dl_r : dr_r;
  assign lo_drop = (dl_r < dr_r) ? dl_r : dr_r;

  always_comb begin
    st0_nxt               = '0;
    st0_nxt.part[L_OPEN]  = (mid_r > hi) ? mid_r - hi : '0;
    st0_nxt.part[L_LEFT]  = dl_r - lo_drop;
    st0_nxt.part[L_RIGHT] = dr_r - lo_drop;
    st0_nxt.part[L_BOTH]  = lo_drop;
    // An empty cell divides by 1.0; its parts are all zero anyway.
    st0_nxt.den           = (mid_r != '0) ? mid_r : ONE;
    for (int i = 0; i < LANES; i++) begin
      st0_nxt.lane[i] = lane_init(st0_nxt.part[i]);
    end
  end

  always_comb begin
    fin = '0;
    for (int i = 0; i < LANES; i++) begin
      fin.part[i] = st_r[QB].part[i];
      fin.rel[i]  = FW'(st_r[QB].lane[i].quo);
    end
  end

  // Control: valid bits and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r    <= 1'b0;
      v_r      <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        a_v_r <= in_valid;
        v_r   <= {v_r[QB-1:0], a_v_r};
      end
      if (out_v_r && out_stall) begin
        // Hold the output; park the word leaving the pipeline.
        if (en && v_r[QB]) begin
          skid_v_r <= 1'b1;
        end
      end else if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= v_r[QB];
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (en) begin
      dl_r    <= dl_nxt;
      dr_r    <= dr_nxt;
      mid_r   <= in_frac_mid;
      st_r[0] <= st0_nxt;
      for (int k = 0; k < QB; k++) begin
        st_r[k+1].part <= st_r[k].part;
        st_r[k+1].den  <= st_r[k].den;
        for (int i = 0; i < LANES; i++) begin
          st_r[k+1].lane[i] <= lane_step(st_r[k].lane[i], st_r[k].den);
        end
      end
    end
    if (out_v_r && out_stall) begin
      // Hold a parked word; capture only while the skid register is empty.
      if (en) begin
        skid_d_r <= fin;
      end
    end else if (skid_v_r) begin
      out_d_r <= skid_d_r;
    end else begin
      out_d_r <= fin;
    end
  end

  assign out_valid      = out_v_r;
  assign out_open_part  = out_d_r.part[L_OPEN];
  assign out_left_part  = out_d_r.part[L_LEFT];
  assign out_right_part = out_d_r.part[L_RIGHT];
  assign out_both_part  = out_d_r.part[L_BOTH];
  assign out_open_rel   = out_d_r.rel[L_OPEN];
  assign out_left_rel   = out_d_r.rel[L_LEFT];
  assign out_right_rel  = out_d_r.rel[L_RIGHT];
  assign out_both_rel   = out_d_r.rel[L_BOTH];

endmodule

`default_nettype wire
